@@ rtl/mwds_pkg.sv @@
// Shared types, constants and the mood prototype ROM for the mood-weighted
// distance score block. No dependencies.
package mwds_pkg;

  localparam int SHORT_BITS = 20;
  localparam int LONG_BITS  = 36;
  localparam logic [3:0] TEMPO_AXIS = 4'd10;
  localparam logic [1:0] MODE_MAJOR = 2'd0;
  localparam logic [1:0] MODE_MINOR = 2'd1;
  localparam logic [1:0] MODE_ANY   = 2'd2;
  localparam int ROM_SLOTS = 6;

  typedef struct packed {
    logic [3:0] axis;
    logic [9:0] target;
    logic [7:0] weight;
  } axis_ent_t;

  typedef struct packed {
    logic [3:0] count;
    logic [1:0] mode;
    logic       tempo;
    axis_ent_t [ROM_SLOTS-1:0] ax;
  } mood_ent_t;

  // Divider request between the sequencer and the shared divider.
  typedef struct packed {
    logic start;
    logic long_op;
  } div_req_t;

  function automatic axis_ent_t ae(input int a, input int t, input int w);
    axis_ent_t e;
    e.axis   = 4'(a);
    e.target = 10'(t);
    e.weight = 8'(w);
    return e;
  endfunction

  function automatic mood_ent_t mood_rom(input logic [3:0] idx);
    mood_ent_t m;
    m = '0;
    m.mode = MODE_ANY;
    case (idx)
      4'd0: begin
        m.count = 4'd6;
        m.ax[0] = ae(0, 420, 10); m.ax[1] = ae(1, 200, 10); m.ax[2] = ae(7, 180, 8);
        m.ax[3] = ae(11, 250, 8); m.ax[4] = ae(5, 300, 4);  m.ax[5] = ae(2, 220, 4);
      end
      4'd1: begin
        m.count = 4'd5;
        m.ax[0] = ae(0, 840, 10); m.ax[1] = ae(1, 810, 10); m.ax[2] = ae(2, 541, 6);
        m.ax[3] = ae(10, 760, 6); m.ax[4] = ae(5, 800, 4);
      end
      4'd2: begin
        m.count = 4'd4; m.mode = MODE_MINOR;
        m.ax[0] = ae(2, 60, 10); m.ax[1] = ae(3, 571, 6); m.ax[2] = ae(8, 250, 5);
        m.ax[3] = ae(0, 650, 3);
      end
      4'd3: begin
        m.count = 4'd4; m.mode = MODE_MAJOR;
        m.ax[0] = ae(2, 583, 10); m.ax[1] = ae(8, 658, 5); m.ax[2] = ae(4, 530, 4);
        m.ax[3] = ae(0, 750, 3);
      end
      4'd4: begin
        m.count = 4'd4;
        m.ax[0] = ae(2, 110, 10); m.ax[1] = ae(4, 550, 8); m.ax[2] = ae(3, 535, 8);
        m.ax[3] = ae(0, 650, 3);
      end
      4'd5: begin
        m.count = 4'd4;
        m.ax[0] = ae(8, 229, 10); m.ax[1] = ae(7, 590, 7); m.ax[2] = ae(6, 65, 6);
        m.ax[3] = ae(5, 750, 3);
      end
      4'd6: begin
        m.count = 4'd4;
        m.ax[0] = ae(6, 510, 9); m.ax[1] = ae(8, 658, 8); m.ax[2] = ae(9, 650, 6);
        m.ax[3] = ae(5, 350, 3);
      end
      4'd7: begin
        m.count = 4'd4;
        m.ax[0] = ae(7, 600, 10); m.ax[1] = ae(5, 300, 7); m.ax[2] = ae(1, 700, 5);
        m.ax[3] = ae(0, 800, 4);
      end
      4'd8: begin
        m.count = 4'd4;
        m.ax[0] = ae(7, 208, 10); m.ax[1] = ae(9, 350, 6); m.ax[2] = ae(5, 480, 4);
        m.ax[3] = ae(2, 330, 3);
      end
      4'd9: begin
        m.count = 4'd4;
        m.ax[0] = ae(1, 200, 10); m.ax[1] = ae(9, 340, 6); m.ax[2] = ae(5, 300, 6);
        m.ax[3] = ae(0, 500, 4);
      end
      4'd10: begin
        m.count = 4'd4;
        m.ax[0] = ae(1, 830, 10); m.ax[1] = ae(9, 660, 6); m.ax[2] = ae(5, 870, 6);
        m.ax[3] = ae(0, 830, 4);
      end
      4'd11: begin
        m.count = 4'd4; m.tempo = 1'b1;
        m.ax[0] = ae(9, 330, 9); m.ax[1] = ae(1, 560, 5); m.ax[2] = ae(10, 540, 6);
        m.ax[3] = ae(7, 300, 4);
      end
      4'd12: begin
        m.count = 4'd2; m.tempo = 1'b1;
        m.ax[0] = ae(11, 165, 10); m.ax[1] = ae(1, 300, 3);
      end
      4'd13: begin
        m.count = 4'd2; m.tempo = 1'b1;
        m.ax[0] = ae(11, 835, 10); m.ax[1] = ae(1, 750, 3);
      end
      4'd14: begin
        m.count = 4'd4; m.mode = MODE_MINOR;
        m.ax[0] = ae(10, 200, 7); m.ax[1] = ae(0, 500, 6); m.ax[2] = ae(2, 170, 5);
        m.ax[3] = ae(1, 300, 5);
      end
      4'd15: begin
        m.count = 4'd4; m.mode = MODE_MAJOR;
        m.ax[0] = ae(10, 800, 7); m.ax[1] = ae(2, 560, 7); m.ax[2] = ae(0, 800, 5);
        m.ax[3] = ae(1, 750, 5);
      end
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage

@@ rtl/mwds_div.sv @@
// Shared restoring divider, one quotient bit per cycle, 20 or 36 steps.
// Depends on mwds_pkg (div_req_t, step counts).
module mwds_div (
  input  logic               clk,
  input  logic               rst,
  input  mwds_pkg::div_req_t req,
  input  logic [35:0]        dividend,
  input  logic [11:0]        divisor,
  output logic               done,
  output logic [35:0]        quotient
);

  logic [35:0] dq;
  logic [11:0] rem;
  logic [11:0] dvs;
  logic [5:0]  cnt;
  logic        running;
  logic [12:0] trial;
  logic        ge;

  assign trial    = {rem, dq[35]};
  assign ge       = trial >= {1'b0, dvs};
  assign quotient = dq;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        running <= 1'b1;
        cnt     <= req.long_op ? 6'(mwds_pkg::LONG_BITS) : 6'(mwds_pkg::SHORT_BITS);
      end else if (running) begin
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dq  <= req.long_op ? dividend : {dividend[19:0], 16'd0};
      rem <= '0;
      dvs <= divisor;
    end else if (running) begin
      rem <= ge ? 12'(trial - {1'b0, dvs}) : trial[11:0];
      dq  <= {dq[34:0], ge};
    end
  end

endmodule

@@ rtl/mood_weighted_distance_score.sv @@
// Top level of the mood-weighted distance score: sequencer, shared multiplier,
// reciprocal scale step, square root steps, APB registers.
// Depends on mwds_pkg and mwds_div.
//
//   channel   | dir | tdata / data                         | tuser
//   s_axis    | in  | axes halves, unread mask, mode, blend| mood_from, mood_to
//   m_axis    | out | score                                | no_score
//   apb       | in  | penalty registers at 0x0 and 0x4     | -
//
// Steps: take, check, then per union axis skip (b repeats an a-axis), drop after
// the blend (zero weight or unread) or use it, then the scaled sum on the shared
// divider (one bit a cycle) and the square root; a word refused at the check, or
// with no used axis, ends with no score. The axis walk and the divider set the time.
// One word is worked at a time; s_tready is high only while the sequencer idles.
// Reset (rst, synchronous) clears the sequencer and output valid, and sets the penalties to 25 and 80.
// A result waits in the output register while m_tready is low; the next
// input word is taken meanwhile and finishes only once that result is gone.
module mood_weighted_distance_score #(
  parameter int AXIS_SCALE    = 1000,
  parameter int MOOD_ENTRIES  = 16,
  parameter int AXIS_COUNT    = 12,
  parameter int MAX_MOOD_AXES = 6
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // [59:0] axes_first_half, [119:60] axes_second_half,
  // [131:120] axis_unread_mask, [133:132] track_mode, [143:134] blend_position
  input  logic [143:0] s_tdata,
  // [3:0] mood_from, [7:4] mood_to
  input  logic [7:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // [10:0] score, [15:11] zero
  output logic [15:0]  m_tdata,
  // [0] no_score
  output logic         m_tuser,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam logic [9:0]  SCALE   = 10'(AXIS_SCALE);
  localparam logic [9:0]  HALF    = 10'(AXIS_SCALE / 2);
  localparam logic [3:0]  MAXN    = 4'(MAX_MOOD_AXES);
  localparam logic [11:0] VALID_AX = 12'((13'd1 << AXIS_COUNT) - 13'd1);
  // Rounded-up reciprocal of the scale; exact for every dividend below 2^20.
  localparam int          RCP_M_I = ((1 << 30) + AXIS_SCALE - 1) / AXIS_SCALE;
  localparam logic [22:0] RCP_M   = 23'(RCP_M_I);

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_CHK  = 5'd1;
  localparam logic [4:0] S_AX   = 5'd2;
  localparam logic [4:0] S_M1   = 5'd3;
  localparam logic [4:0] S_M2   = 5'd4;
  localparam logic [4:0] S_DT   = 5'd5;
  localparam logic [4:0] S_M3   = 5'd6;
  localparam logic [4:0] S_M4   = 5'd7;
  localparam logic [4:0] S_DW   = 5'd8;
  localparam logic [4:0] S_M5   = 5'd9;
  localparam logic [4:0] S_DQ   = 5'd10;
  localparam logic [4:0] S_M6   = 5'd11;
  localparam logic [4:0] S_M7   = 5'd12;
  localparam logic [4:0] S_DF   = 5'd13;
  localparam logic [4:0] S_SQ   = 5'd14;
  localparam logic [4:0] S_FIN  = 5'd15;

  logic [4:0]   state;
  logic [119:0] vals;
  logic [11:0]  unread;
  logic [1:0]   tmode;
  logic [3:0]   mfrom, mto;
  logic [9:0]   tpos;
  logic [3:0]   idx;
  logic [3:0]   axis_r;
  logic [9:0]   ta, tb, tgt;
  logic [7:0]   wa, wb, wt;
  logic [11:0]  q;
  logic [35:0]  acc;
  logic [23:0]  sum;
  logic [11:0]  total;
  logic [31:0]  sq_v, sq_r, sq_bit;
  logic [4:0]   sq_cnt;
  logic [10:0]  res_score;
  logic         res_nos;
  logic [7:0]   pen_unknown, pen_mismatch;
  logic [10:0]  res_score_o;
  logic         res_nos_o;

  mwds_pkg::mood_ent_t ma, mb;
  logic [3:0] na, nb;
  logic [3:0] cur_axis, bslot;
  logic       dup;
  logic [9:0] la_t, lb_t;
  logic [7:0] la_w, lb_w;
  logic [23:0] mul_a;
  logic [11:0] mul_b;
  logic [35:0] prod, acc_add;
  logic [42:0] rcp_prod;
  logic [11:0] rcp_q;
  logic [9:0]  v, dd;
  logic [31:0] sq_try;
  logic [1:0]  mood_mode;
  logic [10:0] pen_score;

  mwds_pkg::div_req_t div_req;
  logic [35:0] div_dividend, div_q;
  logic [11:0] div_divisor;
  logic        div_done;

  mwds_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  assign s_tready = (state == S_IDLE);
  assign pready   = 1'b1;
  assign prdata   = paddr[2] ? {24'd0, pen_mismatch} : {24'd0, pen_unknown};
  assign m_tdata  = {5'd0, res_score_o};
  assign m_tuser  = res_nos_o;

  // Penalty registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pen_unknown  <= 8'd25;
      pen_mismatch <= 8'd80;
    end else if (psel && penable && pwrite) begin
      if (paddr[2]) pen_mismatch <= pwdata[7:0];
      else          pen_unknown  <= pwdata[7:0];
    end
  end

  // Mood walk: union of both lists, skip b-axes already named by a.
  always_comb begin
    ma = mwds_pkg::mood_rom(mfrom);
    mb = mwds_pkg::mood_rom(mto);
    na = (ma.count > MAXN) ? MAXN : ma.count;
    nb = (mb.count > MAXN) ? MAXN : mb.count;
    bslot = idx - na;
    cur_axis = (idx < na) ? ma.ax[idx[2:0]].axis : mb.ax[bslot[2:0]].axis;
    dup  = 1'b0;
    la_t = '0; la_w = '0; lb_t = '0; lb_w = '0;
    // Walk backwards so the first matching slot wins.
    for (int k = mwds_pkg::ROM_SLOTS - 1; k >= 0; k--) begin
      if (4'(k) < na && ma.ax[k].axis == cur_axis) begin
        la_t = ma.ax[k].target;
        la_w = ma.ax[k].weight;
        dup  = 1'b1;
      end
      if (4'(k) < nb && mb.ax[k].axis == cur_axis) begin
        lb_t = mb.ax[k].target;
        lb_w = mb.ax[k].weight;
      end
    end
    if (idx < na) dup = 1'b0;
  end

  // Shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_M1:    begin mul_a = 24'(ta); mul_b = 12'(SCALE - tpos); end
      S_M2:    begin mul_a = 24'(tb); mul_b = 12'(tpos); end
      S_M3:    begin mul_a = 24'(wa); mul_b = 12'(SCALE - tpos); end
      S_M4:    begin mul_a = 24'(wb); mul_b = 12'(tpos); end
      S_M5:    begin mul_a = 24'(dd); mul_b = 12'(dd); end
      S_M6:    begin mul_a = 24'(q);  mul_b = 12'(wt); end
      S_M7:    begin mul_a = sum;     mul_b = 12'(SCALE); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign prod    = 36'(mul_a) * 36'(mul_b);
  assign acc_add = acc + prod;
  // Divide the held 20-bit value by the scale: multiply by the reciprocal.
  assign rcp_prod = 43'(acc[19:0]) * 43'(RCP_M);
  assign rcp_q    = rcp_prod[41:30];
  assign v       = vals[axis_r*10 +: 10];
  assign dd      = (v > tgt) ? (v - tgt) : (tgt - v);
  assign sq_try  = sq_r + sq_bit;

  // Start the divider on the scaled sum, divisor is the total weight.
  always_comb begin
    div_req.start   = (state == S_M7);
    div_req.long_op = (state == S_M7);
    div_dividend    = prod;
    div_divisor     = total;
  end

  always_comb begin
    mood_mode = (tpos < HALF) ? ma.mode : mb.mode;
    pen_score = sq_r[10:0];
    if (mood_mode != mwds_pkg::MODE_ANY) begin
      if (tmode == mwds_pkg::MODE_ANY)  pen_score = 11'(sq_r[10:0] + 11'(pen_unknown));
      else if (tmode != mood_mode)      pen_score = 11'(sq_r[10:0] + 11'(pen_mismatch));
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            vals   <= s_tdata[119:0];
            unread <= s_tdata[131:120] | ~VALID_AX;
            tmode  <= (s_tdata[133:132] == 2'd3) ? mwds_pkg::MODE_ANY : s_tdata[133:132];
            tpos   <= (s_tdata[143:134] > SCALE) ? SCALE : s_tdata[143:134];
            mfrom  <= s_tuser[3:0];
            mto    <= s_tuser[7:4];
            state  <= S_CHK;
          end
        end
        S_CHK: begin
          idx   <= '0;
          sum   <= '0;
          total <= '0;
          if ({1'b0, mfrom} >= 5'(MOOD_ENTRIES) || {1'b0, mto} >= 5'(MOOD_ENTRIES)
              || ((ma.tempo || mb.tempo) && unread[mwds_pkg::TEMPO_AXIS])) begin
            res_nos   <= 1'b1;
            res_score <= '0;
            state     <= S_FIN;
          end else begin
            state <= S_AX;
          end
        end
        S_AX: begin
          if (idx == na + nb) begin
            if (total == '0) begin
              res_nos   <= 1'b1;
              res_score <= '0;
              state     <= S_FIN;
            end else begin
              state <= S_M7;
            end
          end else if (dup) begin
            idx <= idx + 4'd1;
          end else begin
            axis_r <= cur_axis;
            // An axis one mood does not name keeps the other's target.
            ta    <= (la_w == '0) ? lb_t : la_t;
            tb    <= (lb_w == '0) ? la_t : lb_t;
            wa    <= la_w;
            wb    <= lb_w;
            state <= S_M1;
          end
        end
        S_M1: begin acc <= prod; state <= S_M2; end
        S_M2: begin acc <= acc_add; state <= S_DT; end
        S_DT: begin tgt <= rcp_q[9:0]; state <= S_M3; end
        S_M3: begin acc <= prod; state <= S_M4; end
        S_M4: begin acc <= acc_add; state <= S_DW; end
        S_DW: begin
          wt <= rcp_q[7:0];
          if (rcp_q[7:0] == '0 || unread[axis_r]) begin
            idx   <= idx + 4'd1;
            state <= S_AX;
          end else begin
            state <= S_M5;
          end
        end
        S_M5: begin acc <= prod; state <= S_DQ; end
        S_DQ: begin q <= rcp_q; state <= S_M6; end
        S_M6: begin
          sum   <= 24'(sum + prod[23:0]);
          total <= 12'(total + 12'(wt));
          idx   <= idx + 4'd1;
          state <= S_AX;
        end
        S_M7: state <= S_DF;
        S_DF: begin
          if (div_done) begin
            sq_v   <= div_q[31:0];
            sq_r   <= '0;
            sq_bit <= 32'd1 << 30;
            sq_cnt <= 5'd16;
            state  <= S_SQ;
          end
        end
        S_SQ: begin
          if (sq_cnt == '0) begin
            res_nos   <= 1'b0;
            res_score <= pen_score;
            state     <= S_FIN;
          end else begin
            if (sq_v >= sq_try) begin
              sq_v <= sq_v - sq_try;
              sq_r <= (sq_r >> 1) + sq_bit;
            end else begin
              sq_r <= sq_r >> 1;
            end
            sq_bit <= sq_bit >> 2;
            sq_cnt <= sq_cnt - 5'd1;
          end
        end
        S_FIN: if (!m_tvalid || m_tready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // Output register: load when the previous word has left.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      if (state == S_FIN && (!m_tvalid || m_tready)) m_tvalid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FIN && (!m_tvalid || m_tready)) begin
      res_score_o <= res_score;
      res_nos_o   <= res_nos;
    end
  end

endmodule

@@ rtl/mwds_checker.sv @@
// Port-level checks for mood_weighted_distance_score, bound to the top level.
// Depends on the top level's ports only.
module mwds_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic        m_tuser,
  input logic        pready
);

  a_noscore_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[10:0] == 11'd0)
    else $error("no_score word carries a nonzero score");

  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[15:11] == 5'd0)
    else $error("score padding bits set");

  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken again while a word is in work");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled output word changed");

  a_pready: assert property (@(posedge clk) disable iff (rst) pready)
    else $error("pready low");

endmodule

bind mood_weighted_distance_score mwds_checker u_mwds_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .pready   (pready)
);
